>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that b holds in the same cycle as a.
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// Check that b holds in the cycle after a.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/mchw_pkg.sv
`timescale 1ns / 1ps

package mchw_pkg;

    localparam int DEF_CHANNELS           = 15;
    localparam int DEF_COUNTER_BITS       = 12;
    localparam int DEF_STOP_HOLDOFF_TICKS = 50;

    localparam int TIMEOUT_W  = 12;
    localparam int MODE_W     = 6;
    localparam int LIMIT_W    = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;
    localparam int HOLDOFF_W  = 6;
    localparam int MAP_OUT_W  = 15;
    localparam int COUNT_OUT_W = 4;
    localparam int GROUP_W    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_TIMEOUT    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERCEPTION_TIMEOUT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAFETY_TIMEOUT     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NAVIGATION_TIMEOUT = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HARDWARE_TIMEOUT   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_MODE      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_LIMIT     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LIMIT        = 4'd7;

    localparam logic [TIMEOUT_W-1:0] RST_CONTROL_TIMEOUT    = 12'd20;
    localparam logic [TIMEOUT_W-1:0] RST_PERCEPTION_TIMEOUT = 12'd30;
    localparam logic [TIMEOUT_W-1:0] RST_SAFETY_TIMEOUT     = 12'd10;
    localparam logic [TIMEOUT_W-1:0] RST_NAVIGATION_TIMEOUT = 12'd50;
    localparam logic [TIMEOUT_W-1:0] RST_HARDWARE_TIMEOUT   = 12'd20;
    localparam logic [MODE_W-1:0]    RST_CRITICAL_MODE      = 6'd53;
    localparam logic [LIMIT_W-1:0]   RST_CRITICAL_LIMIT     = 4'd2;
    localparam logic [LIMIT_W-1:0]   RST_TOTAL_LIMIT        = 4'd10;

    localparam logic [GROUP_W-1:0] GRP_CONTROL    = 3'd0;
    localparam logic [GROUP_W-1:0] GRP_PERCEPTION = 3'd1;
    localparam logic [GROUP_W-1:0] GRP_SAFETY     = 3'd2;
    localparam logic [GROUP_W-1:0] GRP_NAVIGATION = 3'd3;
    localparam logic [GROUP_W-1:0] GRP_HARDWARE   = 3'd4;

    localparam int AUTO_STOP_BIT = 5;

    localparam logic [1:0] HEALTH_OK       = 2'd0;
    localparam logic [1:0] HEALTH_WARNING  = 2'd1;
    localparam logic [1:0] HEALTH_CRITICAL = 2'd2;

    typedef struct packed {
        logic hb_write;
        logic tick_start;
        logic scan_step;
        logic finish;
    } mchw_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_busy;
    } mchw_status_t;

    function automatic logic [GROUP_W-1:0] group_of(input logic [4:0] ch);
        logic [GROUP_W-1:0] g;
        case (ch)
            5'd0, 5'd1, 5'd2:        g = GRP_CONTROL;
            5'd3, 5'd4, 5'd5, 5'd6:  g = GRP_PERCEPTION;
            5'd7, 5'd8, 5'd9:        g = GRP_SAFETY;
            5'd10, 5'd11:            g = GRP_HARDWARE;
            5'd12, 5'd13, 5'd14:     g = GRP_NAVIGATION;
            default:                 g = GRP_HARDWARE;
        endcase
        return g;
    endfunction

endpackage

>>> hw/rtl/mchw_ctrl.sv
`timescale 1ns / 1ps

module mchw_ctrl
    import mchw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tuser,
    input  mchw_status_t status,
    output logic         s_tready,
    output mchw_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        s_tready       = 1'b0;
        cmd.hb_write   = 1'b0;
        cmd.tick_start = 1'b0;
        cmd.scan_step  = 1'b0;
        cmd.finish     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser)
                    begin
                        cmd.hb_write = 1'b1;
                    end
                    else
                    begin
                        cmd.tick_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the output register can take the result
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/mchw_datapath.sv
`timescale 1ns / 1ps

module mchw_datapath
    import mchw_pkg::*;
#(
    parameter int CHANNELS           = DEF_CHANNELS,
    parameter int COUNTER_BITS       = DEF_COUNTER_BITS,
    parameter int STOP_HOLDOFF_TICKS = DEF_STOP_HOLDOFF_TICKS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mchw_cmd_t             cmd,
    output mchw_status_t          status,
    input  logic [7:0]            s_tdata,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(CHANNELS + 1);
    localparam int CMP_W = (COUNTER_BITS > TIMEOUT_W) ? COUNTER_BITS : TIMEOUT_W;
    localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);
    localparam logic [HOLDOFF_W-1:0] HOLDOFF_LOAD = HOLDOFF_W'(STOP_HOLDOFF_TICKS);

    // configuration
    logic [TIMEOUT_W-1:0] timeout_reg [5];
    logic [MODE_W-1:0]    mode_reg;
    logic [LIMIT_W-1:0]   crit_limit_reg;
    logic [LIMIT_W-1:0]   total_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg[GRP_CONTROL]    <= RST_CONTROL_TIMEOUT;
            timeout_reg[GRP_PERCEPTION] <= RST_PERCEPTION_TIMEOUT;
            timeout_reg[GRP_SAFETY]     <= RST_SAFETY_TIMEOUT;
            timeout_reg[GRP_NAVIGATION] <= RST_NAVIGATION_TIMEOUT;
            timeout_reg[GRP_HARDWARE]   <= RST_HARDWARE_TIMEOUT;
            mode_reg        <= RST_CRITICAL_MODE;
            crit_limit_reg  <= RST_CRITICAL_LIMIT;
            total_limit_reg <= RST_TOTAL_LIMIT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CONTROL_TIMEOUT:    timeout_reg[GRP_CONTROL]    <= cfg_data;
                REG_PERCEPTION_TIMEOUT: timeout_reg[GRP_PERCEPTION] <= cfg_data;
                REG_SAFETY_TIMEOUT:     timeout_reg[GRP_SAFETY]     <= cfg_data;
                REG_NAVIGATION_TIMEOUT: timeout_reg[GRP_NAVIGATION] <= cfg_data;
                REG_HARDWARE_TIMEOUT:   timeout_reg[GRP_HARDWARE]   <= cfg_data;
                REG_CRITICAL_MODE:      mode_reg        <= cfg_data[MODE_W-1:0];
                REG_CRITICAL_LIMIT:     crit_limit_reg  <= cfg_data[LIMIT_W-1:0];
                REG_TOTAL_LIMIT:        total_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // channel state and scan
    logic [COUNTER_BITS-1:0] elapsed_reg [CHANNELS];
    logic [CHANNELS-1:0]     alive_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [CHANNELS-1:0]     map_reg;
    logic [CNT_W-1:0]        failed_reg;
    logic [CNT_W-1:0]        crit_reg;
    logic [HOLDOFF_W-1:0]    holdoff_reg;

    logic [4:0]              hb_ch;
    logic                    hb_in_range;
    logic [4:0]              scan_ch;
    logic [GROUP_W-1:0]      scan_grp;
    logic [COUNTER_BITS-1:0] cnt_cur;
    logic [COUNTER_BITS-1:0] cnt_inc;
    logic                    timed_out;
    logic                    dead;

    assign hb_ch       = {1'b0, s_tdata[3:0]};
    assign hb_in_range = 6'(hb_ch) < 6'(CHANNELS);
    assign scan_ch     = 5'(idx_reg);
    assign scan_grp    = group_of(scan_ch);
    assign cnt_cur     = elapsed_reg[idx_reg];
    assign cnt_inc     = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
    assign timed_out   = CMP_W'(cnt_inc) >= CMP_W'(timeout_reg[scan_grp]);
    assign dead        = timed_out || !alive_reg[idx_reg];

    assign status.scan_last = (idx_reg == LAST_IDX);
    assign status.out_busy  = m_tvalid && !m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                elapsed_reg[i] <= '0;
            end
            alive_reg <= '1;
            idx_reg   <= '0;
        end
        else if (cmd.hb_write)
        begin
            if (hb_in_range)
            begin
                elapsed_reg[hb_ch[IDX_W-1:0]] <= '0;
                alive_reg[hb_ch[IDX_W-1:0]]   <= s_tdata[4];
            end
        end
        else if (cmd.tick_start)
        begin
            idx_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            elapsed_reg[idx_reg] <= cnt_inc;
            alive_reg[idx_reg]   <= !dead;
            idx_reg              <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick_start)
        begin
            map_reg    <= '0;
            failed_reg <= '0;
            crit_reg   <= '0;
        end
        else if (cmd.scan_step && dead)
        begin
            map_reg[idx_reg] <= 1'b1;
            failed_reg       <= failed_reg + 1'b1;
            if (mode_reg[scan_grp])
            begin
                crit_reg <= crit_reg + 1'b1;
            end
        end
    end

    // result
    logic                    over_total;
    logic                    emergency;
    logic [1:0]              health;
    logic [HOLDOFF_W-1:0]    holdoff_dec;
    logic                    stop;
    logic [31:0]             map_wide;
    logic [31:0]             failed_wide;
    logic [31:0]             crit_wide;
    logic                    out_valid_reg;
    logic [31:0]             out_data_reg;

    assign over_total  = LIM_W'(failed_reg) > LIM_W'(total_limit_reg);
    assign emergency   = (LIM_W'(crit_reg) >= LIM_W'(crit_limit_reg)) || over_total;
    assign health      = over_total ? HEALTH_CRITICAL :
                         (failed_reg != '0) ? HEALTH_WARNING : HEALTH_OK;
    assign holdoff_dec = (holdoff_reg != '0) ? holdoff_reg - 1'b1 : holdoff_reg;
    assign stop        = emergency && mode_reg[AUTO_STOP_BIT] && (holdoff_dec == '0);
    assign map_wide    = 32'(map_reg);
    assign failed_wide = 32'(failed_reg);
    assign crit_wide   = 32'(crit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            holdoff_reg   <= stop ? HOLDOFF_LOAD : holdoff_dec;
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg <= {5'd0, stop, emergency, health,
                             crit_wide[COUNT_OUT_W-1:0],
                             failed_wide[COUNT_OUT_W-1:0],
                             map_wide[MAP_OUT_W-1:0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> hw/rtl/multi_channel_heartbeat_watchdog.sv
// Tick item: after accept the controller steps through every channel, then registers
// the result; the datapath updates one channel counter per cycle, and the next tick is
// not accepted before that, nor while a finished result waits on m_tready.
// Heartbeat item: applied in its accept cycle, no result, one per cycle while idle.
// Reset (rst_n low, asynchronous): registers to defaults, counters zero,
// all channels alive, no stop hold-off, no result pending.
`timescale 1ns / 1ps

module multi_channel_heartbeat_watchdog
    import mchw_pkg::*;
#(
    parameter int CHANNELS           = DEF_CHANNELS,
    parameter int COUNTER_BITS       = DEF_COUNTER_BITS,
    parameter int STOP_HOLDOFF_TICKS = DEF_STOP_HOLDOFF_TICKS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // channel_index[3:0], reports_healthy[4]
    input  logic                  s_tuser,   // command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // failed_map[14:0], failed_count[18:15], critical_failed_count[22:19],
    // health_status[24:23], emergency[25], stop_request[26]
    output logic [31:0]           m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    mchw_cmd_t    cmd;
    mchw_status_t status;

    assign cfg_ready = 1'b1;

    mchw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    mchw_datapath #(
        .CHANNELS           (CHANNELS),
        .COUNTER_BITS       (COUNTER_BITS),
        .STOP_HOLDOFF_TICKS (STOP_HOLDOFF_TICKS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> hw/rtl/mchw_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mchw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_IMPLY(a_status_code, clk, rst_n, m_tvalid, m_tdata[24:23] != 2'd3)
    `ASSERT_IMPLY(a_stop_needs_emergency, clk, rst_n, m_tvalid, !m_tdata[26] || m_tdata[25])
    `ASSERT_IMPLY(a_map_vs_status, clk, rst_n, m_tvalid, (m_tdata[14:0] == 15'd0) == (m_tdata[24:23] == 2'd0))

endmodule

bind multi_channel_heartbeat_watchdog mchw_checker u_mchw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mchw_pkg::*;

    localparam int NUM_CH       = DEF_CHANNELS;
    localparam logic [DEF_COUNTER_BITS-1:0] COUNT_MAX = '1;
    localparam logic [HOLDOFF_W-1:0] HOLDOFF_LOAD = HOLDOFF_W'(DEF_STOP_HOLDOFF_TICKS);
    localparam int DRAIN_CYCLES = DEF_CHANNELS + 12;
    localparam int STALL_LIMIT  = 4000;
    localparam int LONG_HOLD    = 400;
    localparam int IDLE_PCT     = 24;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 140;
    localparam int MAX_PRINTS   = 20;

    localparam logic CMD_TICK      = 1'b0;
    localparam logic CMD_HEARTBEAT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = 4'd15;
    localparam logic [3:0]           UNKNOWN_CH     = 4'd15;

    typedef struct packed {
        logic                   stop_request;
        logic                   emergency;
        logic [1:0]             health_status;
        logic [COUNT_OUT_W-1:0] critical_failed_count;
        logic [COUNT_OUT_W-1:0] failed_count;
        logic [MAP_OUT_W-1:0]   failed_map;
    } watchdog_report_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [DEF_COUNTER_BITS-1:0] elapsed_model [NUM_CH];
    logic                        alive_model [NUM_CH];
    logic [HOLDOFF_W-1:0]        holdoff_model;
    logic [TIMEOUT_W-1:0]        timeout_model [5];
    logic [MODE_W-1:0]           mode_model;
    logic [LIMIT_W-1:0]          crit_limit_model;
    logic [LIMIT_W-1:0]          total_limit_model;

    watchdog_report_t pending_reports [$];

    int tx_idle_pct = IDLE_PCT;
    int rx_idle_pct = IDLE_PCT;
    int hold_left = 0;
    int stall_cycles = 0;
    int mismatch_count = 0;
    int n_ticks = 0;
    int n_heartbeats = 0;
    int n_unknown = 0;
    int n_results = 0;
    int n_emergency = 0;
    int n_stops = 0;
    int n_cfg_writes = 0;

    multi_channel_heartbeat_watchdog dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic [GROUP_W-1:0] channel_group(input int ch);
        if (ch <= 2)
            return GRP_CONTROL;
        if (ch <= 6)
            return GRP_PERCEPTION;
        if (ch <= 9)
            return GRP_SAFETY;
        if (ch <= 11)
            return GRP_HARDWARE;
        if (ch <= 14)
            return GRP_NAVIGATION;
        return GRP_HARDWARE;
    endfunction

    function automatic watchdog_report_t advance_tick();
        watchdog_report_t r;
        logic [GROUP_W-1:0] g;
        int failed;
        int crit;
        logic emerg;
        r = '0;
        failed = 0;
        crit = 0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            g = channel_group(i);
            if (elapsed_model[i] != COUNT_MAX)
                elapsed_model[i] = elapsed_model[i] + 1'b1;
            if (elapsed_model[i] >= timeout_model[g])
                alive_model[i] = 1'b0;
            if (!alive_model[i])
            begin
                r.failed_map[i] = 1'b1;
                failed++;
                if (mode_model[g])
                    crit++;
            end
        end
        emerg = (crit >= crit_limit_model) || (failed > total_limit_model);
        if (failed > total_limit_model)
            r.health_status = HEALTH_CRITICAL;
        else if (failed > 0)
            r.health_status = HEALTH_WARNING;
        else
            r.health_status = HEALTH_OK;
        if (holdoff_model != 0)
            holdoff_model = holdoff_model - 1'b1;
        if (emerg && mode_model[AUTO_STOP_BIT] && holdoff_model == 0)
        begin
            r.stop_request = 1'b1;
            holdoff_model = HOLDOFF_LOAD;
        end
        r.failed_count = COUNT_OUT_W'(failed);
        r.critical_failed_count = COUNT_OUT_W'(crit);
        r.emergency = emerg;
        return r;
    endfunction

    function automatic void store_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_CONTROL_TIMEOUT:    timeout_model[GRP_CONTROL] = val[TIMEOUT_W-1:0];
            REG_PERCEPTION_TIMEOUT: timeout_model[GRP_PERCEPTION] = val[TIMEOUT_W-1:0];
            REG_SAFETY_TIMEOUT:     timeout_model[GRP_SAFETY] = val[TIMEOUT_W-1:0];
            REG_NAVIGATION_TIMEOUT: timeout_model[GRP_NAVIGATION] = val[TIMEOUT_W-1:0];
            REG_HARDWARE_TIMEOUT:   timeout_model[GRP_HARDWARE] = val[TIMEOUT_W-1:0];
            REG_CRITICAL_MODE:      mode_model = val[MODE_W-1:0];
            REG_CRITICAL_LIMIT:     crit_limit_model = val[LIMIT_W-1:0];
            REG_TOTAL_LIMIT:        total_limit_model = val[LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("MISMATCH at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin
        watchdog_report_t got;
        watchdog_report_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(watchdog_report_t)-1:0];
                n_results++;
                if (pending_reports.size() == 0)
                    report_mismatch("result with nothing pending, failed_map", got.failed_map, 0);
                else
                begin
                    want = pending_reports.pop_front();
                    if (got.failed_map != want.failed_map)
                        report_mismatch("failed_map", got.failed_map, want.failed_map);
                    if (got.failed_count != want.failed_count)
                        report_mismatch("failed_count", got.failed_count, want.failed_count);
                    if (got.critical_failed_count != want.critical_failed_count)
                        report_mismatch("critical_failed_count", got.critical_failed_count,
                                        want.critical_failed_count);
                    if (got.health_status != want.health_status)
                        report_mismatch("health_status", got.health_status, want.health_status);
                    if (got.emergency != want.emergency)
                        report_mismatch("emergency", got.emergency, want.emergency);
                    if (got.stop_request != want.stop_request)
                        report_mismatch("stop_request", got.stop_request, want.stop_request);
                    n_emergency += want.emergency;
                    n_stops += want.stop_request;
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == CMD_HEARTBEAT)
                begin
                    n_heartbeats++;
                    if (s_tdata[3:0] < NUM_CH)
                    begin
                        elapsed_model[s_tdata[3:0]] = '0;
                        alive_model[s_tdata[3:0]] = s_tdata[4];
                    end
                    else
                        n_unknown++;
                end
                else
                begin
                    n_ticks++;
                    pending_reports.insert(pending_reports.size(), advance_tick());
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                n_cfg_writes++;
                store_register(cfg_index, cfg_data);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles, %0d results pending",
                     STALL_LIMIT, pending_reports.size());
            $display("multi_channel_heartbeat_watchdog regression: fail");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready = 1'b0;
            hold_left--;
        end
        else
            m_tready = ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic send_item(input logic cmd, input logic [3:0] ch, input logic healthy);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = cmd;
        s_tdata = {3'b000, healthy, ch};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_random_item();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            send_item(CMD_TICK, 4'($urandom), 1'($urandom));
        else if (roll < 95)
            send_item(CMD_HEARTBEAT, 4'($urandom_range(0, NUM_CH - 1)),
                      $urandom_range(0, 99) < 85);
        else
            send_item(CMD_HEARTBEAT, UNKNOWN_CH, 1'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(input logic [TIMEOUT_W-1:0] ctl, input logic [TIMEOUT_W-1:0] per,
                             input logic [TIMEOUT_W-1:0] saf, input logic [TIMEOUT_W-1:0] nav,
                             input logic [TIMEOUT_W-1:0] hw, input logic [MODE_W-1:0] mode,
                             input logic [LIMIT_W-1:0] crit, input logic [LIMIT_W-1:0] tot);
        write_reg(REG_CONTROL_TIMEOUT, ctl);
        write_reg(REG_PERCEPTION_TIMEOUT, per);
        write_reg(REG_SAFETY_TIMEOUT, saf);
        write_reg(REG_NAVIGATION_TIMEOUT, nav);
        write_reg(REG_HARDWARE_TIMEOUT, hw);
        write_reg(REG_CRITICAL_MODE, CFG_DATA_W'(mode));
        write_reg(REG_CRITICAL_LIMIT, CFG_DATA_W'(crit));
        write_reg(REG_TOTAL_LIMIT, CFG_DATA_W'(tot));
    endtask

    function automatic logic [TIMEOUT_W-1:0] random_timeout();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return TIMEOUT_W'($urandom_range(1, 40));
        if (roll < 92)
            return TIMEOUT_W'($urandom_range(41, COUNT_MAX));
        return COUNT_MAX;
    endfunction

    function automatic bit pick_register();
        return $urandom_range(0, 9) < 7;
    endfunction

    task automatic write_random_config();
        if (pick_register())
            write_reg(REG_CONTROL_TIMEOUT, random_timeout());
        if (pick_register())
            write_reg(REG_PERCEPTION_TIMEOUT, random_timeout());
        if (pick_register())
            write_reg(REG_SAFETY_TIMEOUT, random_timeout());
        if (pick_register())
            write_reg(REG_NAVIGATION_TIMEOUT, random_timeout());
        if (pick_register())
            write_reg(REG_HARDWARE_TIMEOUT, random_timeout());
        if (pick_register())
            write_reg(REG_CRITICAL_MODE, CFG_DATA_W'($urandom_range(0, (1 << MODE_W) - 1)));
        if (pick_register())
            write_reg(REG_CRITICAL_LIMIT, CFG_DATA_W'($urandom_range(0, (1 << LIMIT_W) - 1)));
        if (pick_register())
            write_reg(REG_TOTAL_LIMIT, CFG_DATA_W'($urandom_range(0, (1 << LIMIT_W) - 1)));
    endtask

    // drop valid, drain results, then let a tick in flight finish
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_item(CMD_HEARTBEAT, UNKNOWN_CH, 1'b0);
        send_item(CMD_HEARTBEAT, 4'd14, 1'b0);
        send_item(CMD_HEARTBEAT, 4'd0, 1'b1);
        send_item(CMD_TICK, 4'hF, 1'b1);
        send_item(CMD_TICK, 4'h0, 1'b0);
        send_item(CMD_HEARTBEAT, 4'd9, 1'b1);
        send_item(CMD_HEARTBEAT, 4'd7, 1'b0);
        send_item(CMD_TICK, 4'hA, 1'b1);
    endtask

    task automatic test_register_extremes();
        wait_idle();
        // zero timeout on control, zero critical limit
        write_all('0, COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX, 6'h3F, '0, 4'hF);
        write_reg(REG_UNUSED_LOW, 12'hFFF);
        write_reg(REG_UNUSED_TOP, 12'h001);
        send_item(CMD_TICK, 4'h5, 1'b0);
        send_item(CMD_TICK, 4'h3, 1'b1);
        send_item(CMD_HEARTBEAT, 4'd1, 1'b1);
        send_item(CMD_TICK, 4'h0, 1'b0);
        wait_idle();
        write_all(12'd1, 12'd1, 12'd1, 12'd1, 12'd1, '0, 4'hF, '0);
        send_item(CMD_TICK, 4'h8, 1'b1);
        send_item(CMD_HEARTBEAT, 4'd3, 1'b1);
        send_item(CMD_TICK, 4'h1, 1'b0);
        send_item(CMD_HEARTBEAT, 4'd8, 1'b0);
        send_item(CMD_TICK, 4'hC, 1'b1);
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        write_all(12'd3, 12'd5, 12'd2, 12'd8, 12'd4, 6'h3F, 4'd1, 4'd3);
        tx_idle_pct = 0;
        hold_left = LONG_HOLD;
        for (int k = 0; k < 8; k++)
        begin
            send_item(CMD_TICK, 4'($urandom), 1'($urandom));
            send_random_item();
        end
        tx_idle_pct = IDLE_PCT;
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int sent;
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            if (p == 0)
                write_all(12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 6'h3F, '0, '0);
            else if (p == 1)
                write_all(COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX, '0, 4'hF, 4'hF);
            else
                write_random_config();
            tx_idle_pct = (p == 3) ? 0 : IDLE_PCT;
            rx_idle_pct = (p == 3) ? 0 : IDLE_PCT;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 4)
                begin
                    // revive every channel
                    for (int c = 0; c < NUM_CH; c++)
                        send_item(CMD_HEARTBEAT, 4'(c), 1'b1);
                    sent += NUM_CH;
                end
                else
                begin
                    send_random_item();
                    sent++;
                end
            end
        end
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
    endtask

    initial
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            elapsed_model[i] = '0;
            alive_model[i] = 1'b1;
        end
        holdoff_model = '0;
        timeout_model[GRP_CONTROL] = RST_CONTROL_TIMEOUT;
        timeout_model[GRP_PERCEPTION] = RST_PERCEPTION_TIMEOUT;
        timeout_model[GRP_SAFETY] = RST_SAFETY_TIMEOUT;
        timeout_model[GRP_NAVIGATION] = RST_NAVIGATION_TIMEOUT;
        timeout_model[GRP_HARDWARE] = RST_HARDWARE_TIMEOUT;
        mode_model = RST_CRITICAL_MODE;
        crit_limit_model = RST_CRITICAL_LIMIT;
        total_limit_model = RST_TOTAL_LIMIT;

        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_output_backpressure();
        test_random_traffic();
        wait_idle();

        if (pending_reports.size() != 0)
            report_mismatch("results never delivered", 0, pending_reports.size());
        $display("summary: %0d ticks, %0d heartbeats (%0d to the unknown channel), %0d results",
                 n_ticks, n_heartbeats, n_unknown, n_results);
        $display("summary: %0d emergencies, %0d stop requests, %0d register writes, %0d mismatches",
                 n_emergency, n_stops, n_cfg_writes, mismatch_count);
        if (mismatch_count == 0)
            $display("multi_channel_heartbeat_watchdog regression: pass");
        else
            $display("multi_channel_heartbeat_watchdog regression: fail");
        $finish;
    end

endmodule
